[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file rau_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rau_pkg.sv]
// Types, codes and helpers for the rational arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    localparam int MAG_W  = 32;
    localparam int PROD_W = 64;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_sm;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } t_prod;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] status;
        t_sm        an;
        t_sm        ad;
        t_sm        bn;
        t_sm        bd;
    } t_item;

    // sign-extend the low vw bits and split into sign and magnitude
    function automatic t_sm to_sm(input logic [MAG_W-1:0] raw, input int unsigned vw);
        logic signed [MAG_W-1:0] sx;
        logic [MAG_W-1:0]        u;
        t_sm                     r;
        sx    = $signed(raw << (MAG_W - vw)) >>> (MAG_W - vw);
        u     = sx;
        r.neg = u[MAG_W-1];
        r.mag = r.neg ? (~u + {{(MAG_W-1){1'b0}}, 1'b1}) : u;
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit, top level: front end, queue and back end.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
// Each transaction carries two fractions and an operation and gives one reduced
// fraction with a status. Error items go from the dequeue step straight to the
// output step. Other items pass a dequeue step, the multiply steps (two products,
// three for add and subtract) and a sum step; a zero sum then goes to the output
// step, and any other sum goes on through a binary gcd whose loop runs as long as
// its operands need, two divisions on the shared divider, a check step and the
// output step. Two items can wait in the queue while the back end works and a
// finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_a_num,
    input  wire logic [31:0] i_a_den,
    input  wire logic [31:0] i_b_num,
    input  wire logic [31:0] i_b_den,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_res_num,
    output logic [30:0]      o_res_den,
    output logic [1:0]       o_status
);

    t_item push_item;
    t_item pop_item;
    logic  push;
    logic  full;
    logic  pop;
    logic  avail;

    rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .i_a_num (i_a_num),
        .i_a_den (i_a_den),
        .i_b_num (i_b_num),
        .i_b_den (i_b_den),
        .i_full  (full),
        .o_push  (push),
        .o_item  (push_item)
    );

    rau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_item  (pop_item)
    );

    rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_avail   (avail),
        .i_item    (pop_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_status  (o_status)
    );

endmodule

`default_nettype wire

[hw/rtl/rau_front.sv]
// Front end: takes input transactions, splits operands and classifies errors.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rau_front import rau_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_a_num,
    input  wire logic [31:0] i_a_den,
    input  wire logic [31:0] i_b_num,
    input  wire logic [31:0] i_b_den,
    input  wire logic        i_full,
    output logic             o_push,
    output t_item            o_item
);

    t_sm an, ad, bn, bd;

    always_comb begin
        an = to_sm(i_a_num, VALUE_WIDTH);
        ad = to_sm(i_a_den, VALUE_WIDTH);
        bn = to_sm(i_b_num, VALUE_WIDTH);
        bd = to_sm(i_b_den, VALUE_WIDTH);
        o_item.mode = i_mode;
        o_item.an   = an;
        o_item.ad   = ad;
        o_item.bn   = bn;
        o_item.bd   = bd;
        if (ad.mag == '0 || bd.mag == '0) begin
            o_item.status = ST_ZERO_DEN;
        end else if (i_mode == MODE_DIV && bn.mag == '0) begin
            o_item.status = ST_DIV_ZERO;
        end else begin
            o_item.status = ST_OK;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid & ~i_full;

endmodule

`default_nettype wire

[hw/rtl/rau_queue.sv]
// Two-entry queue between the front end and the back end.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rau_queue import rau_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_avail,
    output t_item      o_item
);

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_avail = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rd];

endmodule

`default_nettype wire

[hw/rtl/rau_back.sv]
// Back end: cross products, binary gcd, two restoring divisions, result register.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rau_back import rau_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_avail,
    input  wire t_item       i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_res_num,
    output logic [30:0]      o_res_den,
    output logic [1:0]       o_status
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_GCD0 = 4'd3;
    localparam logic [3:0] S_GCD1 = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    localparam logic [PROD_W-1:0] HALF = {{(PROD_W-1){1'b0}}, 1'b1} << (VALUE_WIDTH - 1);
    localparam logic [PROD_W-1:0] ONE  = {{(PROD_W-1){1'b0}}, 1'b1};

    logic [3:0]        r_state;
    logic [1:0]        r_step;
    t_item             r_item;
    t_prod             r_pa;
    t_prod             r_pb;
    t_prod             r_pd;
    logic              r_neg;
    logic [PROD_W-1:0] r_u;
    logic [PROD_W-1:0] r_v;
    logic [5:0]        r_k;
    logic [PROD_W-1:0] r_g;
    logic [PROD_W-1:0] r_q;
    logic [PROD_W:0]   r_rem;
    logic [5:0]        r_cnt;
    logic              r_phase;
    logic [PROD_W-1:0] r_nq;
    logic [PROD_W-1:0] r_dq;
    logic [31:0]       r_res_num;
    logic [30:0]       r_res_den;
    logic [1:0]        r_res_st;
    logic              r_o_valid;
    logic [31:0]       r_o_num;
    logic [30:0]       r_o_den;
    logic [1:0]        r_o_st;

    t_sm               mx;
    t_sm               my;
    t_prod             prod;
    t_prod             tb;
    t_prod             sum;
    logic [PROD_W:0]   rem2;
    logic              qbit;
    logic [PROD_W:0]   rem_n;
    logic [PROD_W-1:0] q_n;
    logic              last_mul;
    logic [PROD_W-1:0] nlim;
    logic [31:0]       nm32;

    always_comb begin
        case (r_step)
            2'd0: begin
                mx = r_item.an;
                my = (r_item.mode == MODE_MUL) ? r_item.bn : r_item.bd;
            end
            2'd1: begin
                mx = r_item.ad;
                my = (r_item.mode == MODE_DIV) ? r_item.bn : r_item.bd;
            end
            default: begin
                mx = r_item.bn;
                my = r_item.ad;
            end
        endcase
        prod.mag = PROD_W'(mx.mag) * PROD_W'(my.mag);
        prod.neg = (mx.neg ^ my.neg) && prod.mag != '0;
        last_mul = (r_item.mode == MODE_ADD || r_item.mode == MODE_SUB) ? (r_step == 2'd2)
                                                                        : (r_step == 2'd1);
    end

    always_comb begin
        tb     = r_pb;
        tb.neg = r_pb.neg ^ (r_item.mode == MODE_SUB && r_pb.mag != '0);
        if (r_item.mode == MODE_MUL || r_item.mode == MODE_DIV) begin
            sum = r_pa;
        end else if (r_pa.neg == tb.neg) begin
            sum.mag = r_pa.mag + tb.mag;
            sum.neg = r_pa.neg;
        end else if (r_pa.mag >= tb.mag) begin
            sum.mag = r_pa.mag - tb.mag;
            sum.neg = r_pa.neg;
        end else begin
            sum.mag = tb.mag - r_pa.mag;
            sum.neg = tb.neg;
        end
    end

    always_comb begin
        rem2  = {r_rem[PROD_W-1:0], r_q[PROD_W-1]};
        qbit  = rem2 >= {1'b0, r_g};
        rem_n = qbit ? (rem2 - {1'b0, r_g}) : rem2;
        q_n   = {r_q[PROD_W-2:0], qbit};
        nlim  = r_neg ? HALF : (HALF - ONE);
        nm32  = r_nq[31:0];
    end

    assign o_pop = (r_state == S_IDLE) && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_o_valid || !i_stall)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_item <= i_item;
                        r_step <= 2'd0;
                        if (i_item.status != ST_OK) begin
                            r_res_num <= 32'd0;
                            r_res_den <= 31'd1;
                            r_res_st  <= i_item.status;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    case (r_step)
                        2'd0:    r_pa <= prod;
                        2'd1:    r_pd <= prod;
                        default: r_pb <= prod;
                    endcase
                    r_step <= r_step + 2'd1;
                    if (last_mul) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (sum.mag == '0) begin
                        r_res_num <= 32'd0;
                        r_res_den <= 31'd1;
                        r_res_st  <= ST_OK;
                        r_state   <= S_OUT;
                    end else begin
                        r_neg   <= sum.neg ^ r_pd.neg;
                        r_q     <= sum.mag;
                        r_u     <= sum.mag;
                        r_v     <= r_pd.mag;
                        r_k     <= 6'd0;
                        r_state <= S_GCD0;
                    end
                end
                S_GCD0: begin
                    if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 6'd1;
                    end else begin
                        r_state <= S_GCD1;
                    end
                end
                S_GCD1: begin
                    if (r_u == '0 || r_v == '0) begin
                        r_g     <= ((r_u == '0) ? r_v : r_u) << r_k;
                        r_rem   <= '0;
                        r_cnt   <= 6'd0;
                        r_phase <= 1'b0;
                        r_state <= S_DIV;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u >= r_v) begin
                        r_u <= r_u - r_v;
                    end else begin
                        r_v <= r_v - r_u;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_rem <= '0;
                        if (!r_phase) begin
                            r_nq    <= q_n;
                            r_q     <= r_pd.mag;
                            r_phase <= 1'b1;
                        end else begin
                            r_dq    <= q_n;
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_rem <= rem_n;
                        r_q   <= q_n;
                    end
                end
                S_FIN: begin
                    if (r_dq > HALF - ONE || r_nq > nlim) begin
                        r_res_num <= 32'd0;
                        r_res_den <= 31'd1;
                        r_res_st  <= ST_OVERFLOW;
                    end else begin
                        r_res_num <= r_neg ? (~nm32 + 32'd1) : nm32;
                        r_res_den <= r_dq[30:0];
                        r_res_st  <= ST_OK;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_num   <= r_res_num;
                        r_o_den   <= r_res_den;
                        r_o_st    <= r_res_st;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_o_valid;
    assign o_res_num = r_o_num;
    assign o_res_den = r_o_den;
    assign o_status  = r_o_st;

endmodule

`default_nettype wire

[hw/rtl/rau_checker.sv]
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rau_checker import rau_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_res_num,
    input wire logic [30:0] o_res_den,
    input wire logic [1:0]  o_status
);

    `RAU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")
    `RAU_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_res_num == 32'd0 && o_res_den == 31'd1, "error result not 0/1")
    `RAU_ASSERT_NOW(a_den_nz, i_clk, i_rst_n, o_valid, o_res_den != 31'd0, "zero result denominator")
    `RAU_ASSERT_NOW(a_zero_norm, i_clk, i_rst_n, o_valid && o_res_num == 32'd0, o_res_den == 31'd1, "zero not given as 0/1")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_res_num (o_res_num),
    .o_res_den (o_res_den),
    .o_status  (o_status)
);

`default_nettype wire

[sim/rational_arithmetic_unit_test.sv]
// Self-checking testbench for the rational arithmetic unit.
// Depends on rau_pkg and rational_arithmetic_unit; directed table, then random transactions.
`timescale 1ns / 1ps

module rational_arithmetic_unit_test import rau_pkg::*; ;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] an, ad, bn, bd;
    } t_op;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  status;
    } t_frac;

    typedef struct {
        t_op   op;
        logic  known;
        t_frac res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [31:0] i_a_num, i_a_den, i_b_num, i_b_den;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_res_num;
    logic [30:0] o_res_den;
    logic [1:0]  o_status;

    t_frac pending_fracs[$];
    t_row  rows[$];
    int    error_count;
    int    cycle_count;
    int    received;
    bit    calm;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam logic [31:0] MIN_INT = 32'h8000_0000;
    localparam logic [31:0] MAX_INT = 32'h7fff_ffff;

    rational_arithmetic_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_a_num(i_a_num), .i_a_den(i_a_den), .i_b_num(i_b_num),
        .i_b_den(i_b_den), .o_valid(o_valid), .i_stall(i_stall),
        .o_res_num(o_res_num), .o_res_den(o_res_den), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_prod mul_sm(input t_prod x, input t_prod y);
        t_prod r;
        r.mag = x.mag * y.mag;
        r.neg = (x.neg != y.neg) && r.mag != 0;
        return r;
    endfunction

    function automatic t_prod add_sm(input t_prod x, input t_prod y);
        t_prod r;
        if (x.neg == y.neg) begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end else begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic t_prod split(input logic [31:0] v);
        t_prod r;
        r.neg = v[31];
        r.mag = {32'd0, v[31] ? (~v + 32'd1) : v};
        return r;
    endfunction

    function automatic t_frac reduce_fraction(input t_op op);
        t_prod an, ad, bn, bd, num, den, t;
        logic [63:0] g, nmag, dmag, half;
        logic        neg;
        t_frac       r;
        an = split(op.an);
        ad = split(op.ad);
        bn = split(op.bn);
        bd = split(op.bd);
        half = 64'h8000_0000;
        r = '{num: 32'd0, den: 31'd1, status: ST_OK};
        if (ad.mag == 0 || bd.mag == 0) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (op.mode == MODE_DIV && bn.mag == 0) begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        case (op.mode)
            MODE_ADD, MODE_SUB: begin
                t = mul_sm(bn, ad);
                if (op.mode == MODE_SUB && t.mag != 0) t.neg = ~t.neg;
                num = add_sm(mul_sm(an, bd), t);
                den = mul_sm(ad, bd);
            end
            MODE_MUL: begin
                num = mul_sm(an, bn);
                den = mul_sm(ad, bd);
            end
            default: begin
                num = mul_sm(an, bd);
                den = mul_sm(ad, bn);
            end
        endcase
        if (num.mag == 0) return r;
        neg = num.neg != den.neg;
        g = gcd64(num.mag, den.mag);
        nmag = num.mag / g;
        dmag = den.mag / g;
        if (dmag > half - 1 || nmag > (neg ? half : half - 1)) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.num = neg ? (32'd0 - nmag[31:0]) : nmag[31:0];
        r.den = dmag[30:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
        error_count++;
    endtask

    task automatic add_row(input t_op op, input logic known, input t_frac res);
        t_row r;
        r.op    = op;
        r.known = known;
        r.res   = res;
        rows    = {rows, r};
    endtask

    task automatic expect_frac(input t_frac f);
        pending_fracs = {pending_fracs, f};
    endtask

    task automatic send(input t_op op);
        i_valid <= 1'b1;
        i_mode  <= op.mode;
        i_a_num <= op.an;
        i_a_den <= op.ad;
        i_b_num <= op.bn;
        i_b_den <= op.bd;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic pause_sender();
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 7))
            0: return MIN_INT;
            1: return MAX_INT;
            2: return 32'd0;
            3: return $urandom_range(0, 20) - 10;
            4: return $urandom_range(0, 2000) - 1000;
            5: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // receive side: random stalls, compare in order
    always @(posedge i_clk) begin
        t_frac want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                received++;
                if (pending_fracs.size() == 0) begin
                    report_mismatch("unexpected result", o_res_num, 32'd0);
                end else begin
                    want = pending_fracs.pop_front();
                    if (o_res_num !== want.num) report_mismatch("res_num", o_res_num, want.num);
                    if (o_res_den !== want.den)
                        report_mismatch("res_den", {1'b0, o_res_den}, {1'b0, want.den});
                    if (o_status !== want.status)
                        report_mismatch("status", {30'd0, o_status}, {30'd0, want.status});
                end
            end
            i_stall <= !calm && ($urandom_range(0, 4) == 0);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_op   op;
        t_frac got;
        int    settle;
        error_count = 0;
        cycle_count = 0;
        received = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_mode = MODE_ADD;
        {i_a_num, i_a_den, i_b_num, i_b_den} = '0;

        add_row('{MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd1}, 1, '{0, 1, ST_ZERO_DEN});
        add_row('{MODE_MUL, 32'd1, 32'd1, 32'd1, 32'd0}, 1, '{0, 1, ST_ZERO_DEN});
        add_row('{MODE_DIV, 32'd3, 32'd0, 32'd0, 32'd2}, 1, '{0, 1, ST_ZERO_DEN});
        add_row('{MODE_DIV, 32'd3, 32'd4, 32'd0, 32'd2}, 1, '{0, 1, ST_DIV_ZERO});
        add_row('{MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd2}, 1, '{1, 1, ST_OK});
        add_row('{MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2}, 1, '{0, 1, ST_OK});
        add_row('{MODE_MUL, 32'd0, -32'd5, 32'd7, 32'd3}, 1, '{0, 1, ST_OK});
        add_row('{MODE_MUL, MAX_INT, 32'd1, 32'd2, 32'd1}, 1, '{0, 1, ST_OVERFLOW});
        add_row('{MODE_MUL, MIN_INT, 32'd1, 32'd1, 32'd1}, 1, '{MIN_INT, 1, ST_OK});
        add_row('{MODE_MUL, MIN_INT, 32'd1, -32'd1, 32'd1}, 1, '{0, 1, ST_OVERFLOW});
        add_row('{MODE_DIV, MIN_INT, MIN_INT, MAX_INT, MAX_INT}, 0, '{0, 1, 0});
        add_row('{MODE_ADD, MAX_INT, MAX_INT, MIN_INT, MIN_INT}, 0, '{0, 1, 0});
        add_row('{MODE_SUB, -32'd3, 32'd4, 32'd5, -32'd6}, 0, '{0, 1, 0});
        add_row('{MODE_DIV, 32'd1, MAX_INT, 32'd1, -32'd1}, 0, '{0, 1, 0});
        add_row('{MODE_DIV, 32'd1, 32'd1, 32'd1, MIN_INT}, 0, '{0, 1, 0});
        add_row('{MODE_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd1}, 0, '{0, 1, 0});
        add_row('{MODE_SUB, MIN_INT, 32'd1, MAX_INT, 32'd1}, 0, '{0, 1, 0});
        add_row('{MODE_MUL, 32'h5555_5555, 32'haaaa_aaab, 32'h3333_3333, 32'd7},
                0, '{0, 1, 0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            got = reduce_fraction(rows[k].op);
            if (rows[k].known && got != rows[k].res) begin
                report_mismatch("table row", got.num, rows[k].res.num);
            end
            expect_frac(rows[k].known ? rows[k].res : got);
            send(rows[k].op);
            pause_sender();
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                // drain completely once
                i_valid <= 1'b0;
                wait (pending_fracs.size() == 0);
                @(posedge i_clk);
            end
            if (k == RANDOM_ITEMS - 200) calm = 1'b1;
            op.mode = 2'($urandom_range(0, 3));
            op.an = rand_field();
            op.ad = rand_field();
            op.bn = rand_field();
            op.bd = rand_field();
            if ($urandom_range(0, 15) != 0 && op.ad == 0) op.ad = 32'd1;
            if ($urandom_range(0, 15) != 0 && op.bd == 0) op.bd = -32'd1;
            expect_frac(reduce_fraction(op));
            send(op);
            pause_sender();
        end
        i_valid <= 1'b0;

        wait (pending_fracs.size() == 0);
        settle = 0;
        while (settle < 500) begin
            @(posedge i_clk);
            settle++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
